@@ rtl/mtdns_pkg.sv @@
// Shared widths, types and helpers for the minimum-total-delay node selector.
package mtdns_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int COUNT_W   = 7;
    localparam int DELAY_W   = 32;
    localparam int TOTAL_W   = 38;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [DELAY_W-1:0] delay_t;
    typedef logic [TOTAL_W-1:0] total_t;

    // Read request: column end total and row owner total, issued as a beat is taken.
    typedef struct packed {
        logic  en;
        node_t col;
        node_t row;
    } store_rd_t;

    // Write of an updated column total, plus a clear of the whole store.
    typedef struct packed {
        logic   en;
        logic   clear;
        node_t  addr;
        total_t data;
    } store_wr_t;

    // Index of the last node for a programmed count, count clamped to 2..MAX_NODES.
    function automatic node_t last_node(input count_t cnt);
        node_t res;
        if (cnt > COUNT_W'(MAX_NODES))
            res = NODE_W'(MAX_NODES - 1);
        else if (cnt < COUNT_W'(2))
            res = NODE_W'(1);
        else
            res = NODE_W'(cnt - COUNT_W'(1));
        return res;
    endfunction

endpackage

@@ rtl/mtdns_store.sv @@
// Per-node total store: one write port, two registered read ports, flag-based clear.
module mtdns_store (
    input  logic                clk,
    input  logic                rst_n,
    input  mtdns_pkg::store_rd_t rd,
    input  mtdns_pkg::store_wr_t wr,
    output mtdns_pkg::total_t    col_total,
    output mtdns_pkg::total_t    row_total
);

    mtdns_pkg::total_t mem [mtdns_pkg::MAX_NODES];
    logic [mtdns_pkg::MAX_NODES-1:0] valid_reg;

    mtdns_pkg::total_t col_mem_reg;
    mtdns_pkg::total_t row_mem_reg;
    mtdns_pkg::total_t col_alt_reg;
    mtdns_pkg::total_t row_alt_reg;
    mtdns_pkg::total_t col_alt_next;
    mtdns_pkg::total_t row_alt_next;
    logic              col_sel_reg;
    logic              row_sel_reg;
    logic              col_sel_next;
    logic              row_sel_next;
    logic              col_hit;
    logic              row_hit;

    // A write landing on the same edge as the read is forwarded; a clear reads as zero.
    always_comb
    begin
        col_hit      = wr.en && (wr.addr == rd.col);
        row_hit      = wr.en && (wr.addr == rd.row);
        col_sel_next = wr.clear || col_hit || !valid_reg[rd.col];
        row_sel_next = wr.clear || row_hit || !valid_reg[rd.row];
        col_alt_next = (col_hit && !wr.clear) ? wr.data : '0;
        row_alt_next = (row_hit && !wr.clear) ? wr.data : '0;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            col_mem_reg <= mem[rd.col];
            row_mem_reg <= mem[rd.row];
            col_alt_reg <= col_alt_next;
            row_alt_reg <= row_alt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            col_sel_reg <= 1'b1;
            row_sel_reg <= 1'b1;
        end
        else
        begin
            if (wr.clear)
                valid_reg <= '0;
            else if (wr.en)
                valid_reg[wr.addr] <= 1'b1;
            if (rd.en)
            begin
                col_sel_reg <= col_sel_next;
                row_sel_reg <= row_sel_next;
            end
        end
    end

    assign col_total = col_sel_reg ? col_alt_reg : col_mem_reg;
    assign row_total = row_sel_reg ? row_alt_reg : row_mem_reg;

endmodule

@@ rtl/min_total_delay_node_select.sv @@
// Top level: node selector by least summed edge delay over a complete graph.
//
// Edge delays arrive one beat per edge in upper-triangle row order and are taken at one
// per clock cycle while the input is not stalled. Each beat passes through an input
// stage, where the 64 x 38-bit node total store is read, and the update stage, which
// accumulates the column and row totals and compares a finished row owner (and, on the
// final edge, the last node) against the best so far. The result is written to the
// output register when the final edge of a round leaves the update stage. The store
// is cleared by per-entry valid flags, so a new round may start on the very next beat.
// The input stalls only while a final edge waits for the output register to be emptied.
// Writing node_count restarts the round and must be done with no beat in flight.
module min_total_delay_node_select (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  mtdns_pkg::count_t         cfg_data,
    input  logic                      edge_valid,
    output logic                      edge_stall,
    input  mtdns_pkg::delay_t         edge_delay,
    output logic                      result_valid,
    input  logic                      result_stall,
    output mtdns_pkg::node_t          best_node,
    output mtdns_pkg::total_t         best_total
);

    // configuration and edge position
    mtdns_pkg::node_t  last_node_reg;
    mtdns_pkg::node_t  last_row_reg;
    mtdns_pkg::node_t  cfg_last_node;
    mtdns_pkg::node_t  row_reg;
    mtdns_pkg::node_t  col_reg;

    // update stage
    logic              s1_valid_reg;
    mtdns_pkg::node_t  s1_row_reg;
    mtdns_pkg::node_t  s1_col_reg;
    logic              s1_last_col_reg;
    logic              s1_last_edge_reg;
    mtdns_pkg::delay_t s1_delay_reg;

    mtdns_pkg::total_t row_sum_reg;
    logic              have_best_reg;
    mtdns_pkg::node_t  best_idx_reg;
    mtdns_pkg::total_t best_val_reg;

    logic              out_valid_reg;
    mtdns_pkg::node_t  out_node_reg;
    mtdns_pkg::total_t out_total_reg;

    logic              edge_accept;
    logic              s1_hold;
    logic              s1_fire;
    logic              pos_last_col;
    logic              pos_last_edge;

    mtdns_pkg::store_rd_t st_rd;
    mtdns_pkg::store_wr_t st_wr;
    mtdns_pkg::total_t    col_old;
    mtdns_pkg::total_t    row_old;

    mtdns_pkg::total_t delay_ext;
    mtdns_pkg::total_t col_sum;
    mtdns_pkg::total_t row_cand;
    logic              take_row;
    logic              take_last;
    mtdns_pkg::node_t  mid_idx;
    mtdns_pkg::total_t mid_val;
    mtdns_pkg::node_t  fin_idx;
    mtdns_pkg::total_t fin_val;

    assign s1_hold     = s1_valid_reg && s1_last_edge_reg && out_valid_reg && result_stall;
    assign s1_fire     = s1_valid_reg && !s1_hold;
    assign edge_stall  = s1_hold;
    assign edge_accept = edge_valid && !edge_stall;

    assign cfg_last_node = mtdns_pkg::last_node(cfg_data);
    assign pos_last_col  = (col_reg == last_node_reg);
    assign pos_last_edge = pos_last_col && (row_reg == last_row_reg);

    always_comb
    begin
        st_rd.en    = edge_accept;
        st_rd.col   = col_reg;
        st_rd.row   = row_reg;
        st_wr.en    = s1_fire;
        st_wr.clear = (s1_fire && s1_last_edge_reg) || cfg_write;
        st_wr.addr  = s1_col_reg;
        st_wr.data  = col_sum;
    end

    mtdns_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (st_rd),
        .wr        (st_wr),
        .col_total (col_old),
        .row_total (row_old)
    );

    // Row owner's total is final at its row end; the last node is judged after it.
    always_comb
    begin
        delay_ext = mtdns_pkg::TOTAL_W'(s1_delay_reg);
        col_sum   = col_old + delay_ext;
        row_cand  = row_old + row_sum_reg + delay_ext;
        take_row  = !have_best_reg || (row_cand < best_val_reg);
        mid_idx   = take_row ? s1_row_reg : best_idx_reg;
        mid_val   = take_row ? row_cand : best_val_reg;
        take_last = take_row ? (col_sum < row_cand) : (col_sum < best_val_reg);
        fin_idx   = take_last ? s1_col_reg : mid_idx;
        fin_val   = take_last ? col_sum : mid_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_node_reg <= mtdns_pkg::NODE_W'(1);
            last_row_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= mtdns_pkg::NODE_W'(1);
            s1_valid_reg  <= 1'b0;
            row_sum_reg   <= '0;
            have_best_reg <= 1'b0;
            best_idx_reg  <= '0;
            best_val_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= edge_accept || s1_hold;

            if (cfg_write)
            begin
                last_node_reg <= cfg_last_node;
                last_row_reg  <= cfg_last_node - mtdns_pkg::NODE_W'(1);
                row_reg       <= '0;
                col_reg       <= mtdns_pkg::NODE_W'(1);
            end
            else if (edge_accept)
            begin
                if (pos_last_edge)
                begin
                    row_reg <= '0;
                    col_reg <= mtdns_pkg::NODE_W'(1);
                end
                else if (pos_last_col)
                begin
                    row_reg <= row_reg + mtdns_pkg::NODE_W'(1);
                    col_reg <= row_reg + mtdns_pkg::NODE_W'(2);
                end
                else
                begin
                    col_reg <= col_reg + mtdns_pkg::NODE_W'(1);
                end
            end

            if (cfg_write)
            begin
                row_sum_reg   <= '0;
                have_best_reg <= 1'b0;
                best_idx_reg  <= '0;
                best_val_reg  <= '0;
            end
            else if (s1_fire)
            begin
                row_sum_reg <= s1_last_col_reg ? '0 : row_sum_reg + delay_ext;
                if (s1_last_edge_reg)
                begin
                    have_best_reg <= 1'b0;
                    best_idx_reg  <= '0;
                    best_val_reg  <= '0;
                end
                else if (s1_last_col_reg && take_row)
                begin
                    have_best_reg <= 1'b1;
                    best_idx_reg  <= s1_row_reg;
                    best_val_reg  <= row_cand;
                end
            end

            if (out_valid_reg && !result_stall)
                out_valid_reg <= 1'b0;
            if (s1_fire && s1_last_edge_reg)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (edge_accept)
        begin
            s1_row_reg       <= row_reg;
            s1_col_reg       <= col_reg;
            s1_last_col_reg  <= pos_last_col;
            s1_last_edge_reg <= pos_last_edge;
            s1_delay_reg     <= edge_delay;
        end
        if (s1_fire && s1_last_edge_reg)
        begin
            out_node_reg  <= fin_idx;
            out_total_reg <= fin_val;
        end
    end

    assign result_valid = out_valid_reg;
    assign best_node    = out_node_reg;
    assign best_total   = out_total_reg;

endmodule

@@ rtl/mtdns_checker.sv @@
// Port-level assertions for the node selector, bound to the top level.
module mtdns_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                edge_valid,
    input logic                edge_stall,
    input logic                result_valid,
    input logic                result_stall,
    input mtdns_pkg::node_t    best_node,
    input mtdns_pkg::total_t   best_total
);

    // a stalled result beat stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(best_node)
                                         && $stable(best_total))
        else $error("result beat changed while stalled");

    // input backpressure only comes from a blocked output register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        edge_stall |-> result_valid && result_stall)
        else $error("edge stalled with output free");

    // a fresh result must be preceded by an accepted edge beat
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(edge_valid && !edge_stall, 2))
        else $error("result appeared without a preceding edge beat");

endmodule

bind min_total_delay_node_select mtdns_checker u_mtdns_checker (.*);
